@@ sv/gtarb_pkg.sv @@
// shared types and constants for the gpio timer adc register block
package gtarb_pkg;

    // sizing of the port latches and of the adc sample store
    localparam int PORT_WIDTH   = 16;
    localparam int ADC_CHANNELS = 16;
    localparam int ADC_IDX_W    = (ADC_CHANNELS > 1) ? $clog2(ADC_CHANNELS) : 1;

    localparam int DATA_W = 16;
    localparam int ADDR_W = 7;
    localparam int CHAN_W = 4;
    localparam int FREQ_W = 12;
    localparam int PRE_W  = 15;

    // timer control fields
    localparam int TMR_ENABLE_BIT = 15;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_LOAD  = 2'd3
    } act_t;

    // register byte addresses
    localparam logic [ADDR_W-1:0] ADDR_PORT_A   = 7'd0;
    localparam logic [ADDR_W-1:0] ADDR_DIR_A    = 7'd2;
    localparam logic [ADDR_W-1:0] ADDR_PORT_B   = 7'd4;
    localparam logic [ADDR_W-1:0] ADDR_DIR_B    = 7'd6;
    localparam logic [ADDR_W-1:0] ADDR_TMR_CNT  = 7'd8;
    localparam logic [ADDR_W-1:0] ADDR_TMR_STAT = 7'd10;
    localparam logic [ADDR_W-1:0] ADDR_TMR_CTRL = 7'd12;
    localparam logic [ADDR_W-1:0] ADDR_TMR_PER  = 7'd14;
    localparam logic [ADDR_W-1:0] ADDR_FREQ     = 7'd16;
    localparam logic [ADDR_W-1:0] ADDR_ADC_SEL  = 7'd66;
    localparam logic [ADDR_W-1:0] ADDR_ADC_DATA = 7'd68;

endpackage

@@ sv/gtarb_if.sv @@
// valid/ready channel interfaces for requests and results
interface gtarb_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [6:0]  reg_addr;
    logic [15:0] write_data;
    logic [3:0]  sample_channel;

    modport source (output valid, output action, output reg_addr, output write_data,
                    output sample_channel, input ready);
    modport sink   (input valid, input action, input reg_addr, input write_data,
                    input sample_channel, output ready);
endinterface

interface gtarb_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic [15:0] port_a_level;
    logic [15:0] port_b_level;
    logic [15:0] dir_a_mask;
    logic [15:0] dir_b_mask;
    logic        timer_overflowed;

    modport source (output valid, output read_data, output port_a_level,
                    output port_b_level, output dir_a_mask, output dir_b_mask,
                    output timer_overflowed, input ready);
    modport sink   (input valid, input read_data, input port_a_level,
                    input port_b_level, input dir_a_mask, input dir_b_mask,
                    input timer_overflowed, output ready);
endinterface

@@ sv/gpio_timer_adc_register_block_core.sv @@
// gpio, timer and adc register block: one bus action per transfer
// a request transfer is answered by a registered result in the next cycle
// throughput: one transfer per cycle while rsp.ready holds; all work for
//   an action is a short combinational pass from state to result register
// reset: rst_n clears ports, directions, timer, adc select and sample store,
//   the frequency register and the result valid flag
module gpio_timer_adc_register_block_core (
    input  logic                         clk,
    input  logic                         rst_n,
    gtarb_req_if.sink                    req,
    gtarb_rsp_if.source                  rsp,
    input  logic                         cfg_wr_en,
    input  logic [gtarb_pkg::FREQ_W-1:0] cfg_wr_data
);
    import gtarb_pkg::*;

    // architectural state
    logic [PORT_WIDTH-1:0] port_a_reg, port_a_next;
    logic [PORT_WIDTH-1:0] port_b_reg, port_b_next;
    logic [PORT_WIDTH-1:0] dir_a_reg, dir_a_next;
    logic [PORT_WIDTH-1:0] dir_b_reg, dir_b_next;
    logic [DATA_W-1:0]     tmr_cnt_reg, tmr_cnt_next;
    logic [DATA_W-1:0]     tmr_stat_reg, tmr_stat_next;
    logic [DATA_W-1:0]     tmr_ctrl_reg, tmr_ctrl_next;
    logic [DATA_W-1:0]     tmr_per_reg, tmr_per_next;
    logic [PRE_W-1:0]      pre_cnt_reg, pre_cnt_next;
    logic [CHAN_W-1:0]     adc_sel_reg, adc_sel_next;
    logic [FREQ_W-1:0]     freq_reg;
    logic [DATA_W-1:0]     adc_store_reg [ADC_CHANNELS];

    // result stage
    logic              rsp_valid_reg;
    logic [DATA_W-1:0] rd_data_reg, rd_data_next;

    logic req_fire;
    act_t act;

    // write data sized to the port latch width
    logic [PORT_WIDTH+DATA_W-1:0] wd_wide;
    logic [PORT_WIDTH-1:0]        wd_port;

    // timer tick helpers
    logic [PRE_W-1:0]  pre_inc;
    logic [PRE_W-1:0]  pre_limit;
    logic [DATA_W-1:0] cnt_inc;
    logic              pre_match;

    // adc store access
    logic                 load_ok;
    logic                 sel_ok;
    logic [ADC_IDX_W-1:0] load_idx;
    logic [ADC_IDX_W-1:0] sel_idx;

    // zero-extended views of the port latches for the 16-bit bus
    logic [PORT_WIDTH+DATA_W-1:0] port_a_wide, port_b_wide, dir_a_wide, dir_b_wide;

    // the result register drains whenever the sink takes it, so a new
    // request can land in the same cycle a finished result leaves
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign req_fire  = req.valid && req.ready;
    assign act       = act_t'(req.action);

    assign wd_wide = {{PORT_WIDTH{1'b0}}, req.write_data};
    assign wd_port = wd_wide[PORT_WIDTH-1:0];

    assign port_a_wide = {{DATA_W{1'b0}}, port_a_reg};
    assign port_b_wide = {{DATA_W{1'b0}}, port_b_reg};
    assign dir_a_wide  = {{DATA_W{1'b0}}, dir_a_reg};
    assign dir_b_wide  = {{DATA_W{1'b0}}, dir_b_reg};

    // prescaler runs every enabled tick; a zero prescale never matches
    assign pre_inc   = pre_cnt_reg + 1'b1;
    assign pre_limit = tmr_ctrl_reg[PRE_W-1:0];
    assign pre_match = (pre_limit != '0) && (pre_inc == pre_limit);
    assign cnt_inc   = tmr_cnt_reg + 1'b1;

    // channels beyond the store are dropped on load and read as zero
    assign load_ok  = ({1'b0, req.sample_channel} < (CHAN_W+1)'(ADC_CHANNELS));
    assign sel_ok   = ({1'b0, adc_sel_reg} < (CHAN_W+1)'(ADC_CHANNELS));
    assign load_idx = req.sample_channel[ADC_IDX_W-1:0];
    assign sel_idx  = adc_sel_reg[ADC_IDX_W-1:0];

    // next state and read data for the action at the request port
    always_comb
    begin
        port_a_next   = port_a_reg;
        port_b_next   = port_b_reg;
        dir_a_next    = dir_a_reg;
        dir_b_next    = dir_b_reg;
        tmr_cnt_next  = tmr_cnt_reg;
        tmr_stat_next = tmr_stat_reg;
        tmr_ctrl_next = tmr_ctrl_reg;
        tmr_per_next  = tmr_per_reg;
        pre_cnt_next  = pre_cnt_reg;
        adc_sel_next  = adc_sel_reg;
        rd_data_next  = '0;

        unique case (act)
            ACT_TICK:
            begin
                if (tmr_ctrl_reg[TMR_ENABLE_BIT])
                begin
                    pre_cnt_next = pre_inc;
                    if (pre_match)
                    begin
                        pre_cnt_next = '0;
                        tmr_cnt_next = cnt_inc;
                        // period reached: wrap and flag overflow
                        if (cnt_inc == tmr_per_reg)
                        begin
                            tmr_cnt_next     = '0;
                            tmr_stat_next[0] = 1'b1;
                        end
                    end
                end
            end
            ACT_WRITE:
            begin
                unique case (req.reg_addr)
                    // only output pins (direction 0) take the new value
                    ADDR_PORT_A:   port_a_next   = (wd_port & ~dir_a_reg) | (port_a_reg & dir_a_reg);
                    ADDR_DIR_A:    dir_a_next    = wd_port;
                    ADDR_PORT_B:   port_b_next   = (wd_port & ~dir_b_reg) | (port_b_reg & dir_b_reg);
                    ADDR_DIR_B:    dir_b_next    = wd_port;
                    ADDR_TMR_CNT:  tmr_cnt_next  = req.write_data;
                    ADDR_TMR_STAT: tmr_stat_next = req.write_data;
                    ADDR_TMR_CTRL: tmr_ctrl_next = req.write_data;
                    ADDR_TMR_PER:  tmr_per_next  = req.write_data;
                    ADDR_ADC_SEL:  adc_sel_next  = req.write_data[CHAN_W-1:0];
                    default:       ;
                endcase
            end
            ACT_READ:
            begin
                unique case (req.reg_addr)
                    ADDR_PORT_A:   rd_data_next = port_a_wide[DATA_W-1:0];
                    ADDR_DIR_A:    rd_data_next = dir_a_wide[DATA_W-1:0];
                    ADDR_PORT_B:   rd_data_next = port_b_wide[DATA_W-1:0];
                    ADDR_DIR_B:    rd_data_next = dir_b_wide[DATA_W-1:0];
                    ADDR_TMR_CNT:  rd_data_next = tmr_cnt_reg;
                    ADDR_TMR_STAT: rd_data_next = tmr_stat_reg;
                    ADDR_TMR_CTRL: rd_data_next = tmr_ctrl_reg;
                    ADDR_TMR_PER:  rd_data_next = tmr_per_reg;
                    ADDR_FREQ:     rd_data_next = {{(DATA_W-FREQ_W){1'b0}}, freq_reg};
                    ADDR_ADC_SEL:  rd_data_next = {{(DATA_W-CHAN_W){1'b0}}, adc_sel_reg};
                    ADDR_ADC_DATA: rd_data_next = sel_ok ? adc_store_reg[sel_idx] : '0;
                    // serial-interface, odd and unmapped addresses read zero
                    default:       rd_data_next = '0;
                endcase
            end
            ACT_LOAD:
            begin
                // sample store is written in its own clocked block
            end
            default:
            begin
            end
        endcase
    end

    // state registers update only on a request transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_a_reg   <= '0;
            port_b_reg   <= '0;
            dir_a_reg    <= '0;
            dir_b_reg    <= '0;
            tmr_cnt_reg  <= '0;
            tmr_stat_reg <= '0;
            tmr_ctrl_reg <= '0;
            tmr_per_reg  <= '0;
            pre_cnt_reg  <= '0;
            adc_sel_reg  <= '0;
        end
        else if (req_fire)
        begin
            port_a_reg   <= port_a_next;
            port_b_reg   <= port_b_next;
            dir_a_reg    <= dir_a_next;
            dir_b_reg    <= dir_b_next;
            tmr_cnt_reg  <= tmr_cnt_next;
            tmr_stat_reg <= tmr_stat_next;
            tmr_ctrl_reg <= tmr_ctrl_next;
            tmr_per_reg  <= tmr_per_next;
            pre_cnt_reg  <= pre_cnt_next;
            adc_sel_reg  <= adc_sel_next;
        end
    end

    // adc sample store, cleared by reset, one write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ADC_CHANNELS; i++)
            begin
                adc_store_reg[i] <= '0;
            end
        end
        else if (req_fire && (act == ACT_LOAD) && load_ok)
        begin
            adc_store_reg[load_idx] <= req.write_data;
        end
    end

    // frequency register from the configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            freq_reg <= cfg_wr_data;
        end
    end

    // result stage: valid flag and read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (req_fire)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            rd_data_reg <= rd_data_next;
        end
    end

    // the state seen after an action holds until the next request transfer,
    // and none can happen while a result waits with rsp.ready low
    assign rsp.valid            = rsp_valid_reg;
    assign rsp.read_data        = rd_data_reg;
    assign rsp.port_a_level     = port_a_wide[DATA_W-1:0];
    assign rsp.port_b_level     = port_b_wide[DATA_W-1:0];
    assign rsp.dir_a_mask       = dir_a_wide[DATA_W-1:0];
    assign rsp.dir_b_mask       = dir_b_wide[DATA_W-1:0];
    assign rsp.timer_overflowed = tmr_stat_reg[0];

    // state only moves on a request transfer
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !req_fire |=> $stable(port_a_reg) && $stable(tmr_cnt_reg) && $stable(pre_cnt_reg))
        else $error("state changed without a request transfer");

    // only a read transfer returns non-zero data
    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && (act != ACT_READ) |=> rsp.read_data == '0)
        else $error("non-read action returned read data");

    // overflow flag rises only from a tick or a status write
    a_ovf_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(tmr_stat_reg[0]) |-> $past(req_fire)
            && ($past(act) == ACT_TICK || $past(act) == ACT_WRITE))
        else $error("timer overflow set without tick or write");

    // a zero prescale never advances the timer count on a tick
    a_zero_prescale: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && (act == ACT_TICK) && (pre_limit == '0) |=> $stable(tmr_cnt_reg))
        else $error("timer advanced with zero prescale");

endmodule
